// ===== hdl/internet_checksum_stream_defines.svh =====
// ---------------------------------------------------------------------------
// internet checksum stream assertion macros
// shared property wrappers for the checksum block
// ---------------------------------------------------------------------------
`ifndef INTERNET_CHECKSUM_STREAM_DEFINES_SVH
`define INTERNET_CHECKSUM_STREAM_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define ICS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define ICS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ics_pkg.sv =====
// ---------------------------------------------------------------------------
// ics_pkg
// types, constants and the ones-complement adder of the checksum block
// ---------------------------------------------------------------------------
package ics_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam logic [WORD_W-1:0] ALL_ONES = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
        logic [WORD_W-1:0] skip_offset;
        logic [WORD_W-1:0] sum_length;
    } t_beat;

    typedef struct packed {
        logic [WORD_W-1:0] checksum;
        logic              bad_offset;
        logic              short_data;
    } t_result;

    // 16-bit add with end-around carry
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] acc,
                                                 input logic [WORD_W-1:0] word);
        logic [WORD_W:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

// ===== hdl/ics_in_reg.sv =====
// ---------------------------------------------------------------------------
// ics_in_reg
// input register stage holding one accepted beat for the summing logic
// ---------------------------------------------------------------------------
module ics_in_reg
    import ics_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_beat i_beat,
    input  logic  i_take,
    output logic  o_ready,
    output logic  o_valid,
    output t_beat o_beat
);

    logic  r_valid;
    t_beat r_beat;
    logic  n_valid;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_take ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== hdl/ics_sum_core.sv =====
// ---------------------------------------------------------------------------
// ics_sum_core
// packet state and ones-complement sum, one beat per step
// ---------------------------------------------------------------------------
module ics_sum_core
    import ics_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_beat   i_beat,
    input  logic    i_step,
    output logic    o_has_result,
    output t_result o_result
);

`include "internet_checksum_stream_defines.svh"

    logic [WORD_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_hold, n_hold;
    logic              r_odd, n_odd;
    logic [WORD_W-1:0] r_skip, n_skip;
    logic [WORD_W-1:0] r_left, n_left;
    logic              r_in_packet, n_in_packet;
    logic              was_skip;
    logic              has_result;
    logic [WORD_W-1:0] fin_sum;

    always_comb begin
        n_sum       = r_sum;
        n_hold      = r_hold;
        n_odd       = r_odd;
        n_skip      = r_skip;
        n_left      = r_left;
        n_in_packet = r_in_packet;
        was_skip    = 1'b0;
        has_result  = 1'b0;

        // first beat restarts the packet, abandoning any open one
        if (i_beat.first_byte) begin
            n_sum       = '0;
            n_hold      = '0;
            n_odd       = 1'b0;
            n_skip      = i_beat.skip_offset;
            n_left      = i_beat.sum_length;
            n_in_packet = 1'b1;
        end

        if (n_in_packet) begin
            if (n_skip != '0) begin
                n_skip   = n_skip - WORD_W'(1);
                was_skip = 1'b1;
            end else if (n_left != '0) begin
                n_left = n_left - WORD_W'(1);
                if (n_odd) begin
                    n_sum = oc_add(n_sum, {n_hold, i_beat.data_byte});
                    n_odd = 1'b0;
                end else begin
                    n_hold = i_beat.data_byte;
                    n_odd  = 1'b1;
                end
            end
            if (i_beat.last_byte) begin
                has_result  = 1'b1;
                n_in_packet = 1'b0;
            end
        end
    end

    // trailing odd byte gets a zero low byte
    assign fin_sum = n_odd ? oc_add(n_sum, {n_hold, {BYTE_W{1'b0}}}) : n_sum;

    always_comb begin
        if (was_skip) begin
            o_result.checksum   = ALL_ONES;
            o_result.bad_offset = 1'b1;
            o_result.short_data = 1'b0;
        end else begin
            o_result.checksum   = ~fin_sum;
            o_result.bad_offset = 1'b0;
            o_result.short_data = (n_left != '0);
        end
    end

    assign o_has_result = i_valid && has_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_hold      <= '0;
            r_odd       <= 1'b0;
            r_skip      <= '0;
            r_left      <= '0;
            r_in_packet <= 1'b0;
        end else if (i_step) begin
            r_sum       <= n_sum;
            r_hold      <= n_hold;
            r_odd       <= n_odd;
            r_skip      <= n_skip;
            r_left      <= n_left;
            r_in_packet <= n_in_packet;
        end
    end

    `ICS_ASSERT_NEXT(a_close_on_result, i_clk, i_rst_n, i_step && o_has_result, !r_in_packet, "packet still open after its result")
    `ICS_ASSERT_IMPL(a_result_needs_beat, i_clk, i_rst_n, o_has_result, i_valid, "result without a held beat")

endmodule

// ===== hdl/ics_out_reg.sv =====
// ---------------------------------------------------------------------------
// ics_out_reg
// result register decoupling the summing logic from the output consumer
// ---------------------------------------------------------------------------
module ics_out_reg
    import ics_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hdl/internet_checksum_stream.sv =====
// ---------------------------------------------------------------------------
// internet_checksum_stream
// streaming internet checksum over packet bytes with skip offset and length
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  in       | i_in_valid / o_in_ready   | data_byte first last skip length
//  out      | o_out_valid / i_out_ready | checksum bad_offset short_data
//
//  one beat per cycle unless a held result stalls a closing beat: a beat sits
//  in the input register, then the 16-bit end-around-carry add updates the
//  packet state and loads the result register as a packet's last beat leaves.
//  synchronous active-low reset clears valids and packet state, no sweep.
//  a held result stalls only a beat that closes a packet; o_in_ready then
//  stays low until the held result is taken.
// ---------------------------------------------------------------------------
module internet_checksum_stream
    import ics_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    input  logic [WORD_W-1:0] i_skip_offset,
    input  logic [WORD_W-1:0] i_sum_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_checksum,
    output logic              o_bad_offset,
    output logic              o_short_data
);

`include "internet_checksum_stream_defines.svh"

    t_beat   in_beat;
    t_beat   s1_beat;
    logic    s1_valid;
    logic    s1_take;
    logic    has_result;
    t_result core_result;
    t_result out_result;
    logic    out_free;

    assign in_beat.data_byte   = i_data_byte;
    assign in_beat.first_byte  = i_first_byte;
    assign in_beat.last_byte   = i_last_byte;
    assign in_beat.skip_offset = i_skip_offset;
    assign in_beat.sum_length  = i_sum_length;

    // beats without a result never wait on the output side
    assign s1_take = s1_valid && (!has_result || out_free);

    ics_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_beat  (in_beat),
        .i_take  (s1_take),
        .o_ready (o_in_ready),
        .o_valid (s1_valid),
        .o_beat  (s1_beat)
    );

    ics_sum_core u_sum_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s1_valid),
        .i_beat       (s1_beat),
        .i_step       (s1_take),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    ics_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_take && has_result),
        .i_result (core_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_checksum   = out_result.checksum;
    assign o_bad_offset = out_result.bad_offset;
    assign o_short_data = out_result.short_data;

    `ICS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, s1_take && has_result, !o_out_valid || i_out_ready, "result register overwritten")
    `ICS_ASSERT_NEXT(a_stage_held, i_clk, i_rst_n, s1_valid && !s1_take, s1_valid, "held beat dropped")

endmodule
